### rtl/binomial_coefficient_top_assert.svh
// ---------------------------------------------------------------------------
// binomial_coefficient_top_assert.svh
// Assertion macros for the binomial coefficient block; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef BINOMIAL_COEFFICIENT_TOP_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define BINC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define BINC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BINC_ASSERT(lbl, prop, msg)
`define BINC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/binc_pkg.sv
// ---------------------------------------------------------------------------
// binc_pkg
// Shared widths, defaults and sequencer states of the binomial coefficient block.
// ---------------------------------------------------------------------------
`default_nettype none

package binc_pkg;

    localparam int FIELD_W   = 7;   // input field width, signed
    localparam int N_W       = 6;   // n after range check
    localparam int IDX_W     = 5;   // step index, min(k, n-k) <= 31
    localparam int ACC_W     = 60;  // accumulator and result width
    localparam int PROD_W    = ACC_W + N_W;  // acc * (n-i+1)
    localparam int MAX_N_DEF = 63;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } binc_state_t;

endpackage

`default_nettype wire

### rtl/binc_div.sv
// ---------------------------------------------------------------------------
// binc_div
// Restoring divider, one quotient bit per cycle, small divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module binc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [binc_pkg::PROD_W-1:0]   dividend,
    input  wire logic [binc_pkg::IDX_W-1:0]    divisor,
    output logic                               done,
    output logic [binc_pkg::PROD_W-1:0]        quotient
);

    import binc_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [PROD_W-1:0] q_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  den_reg;
    logic [IDX_W:0]    trial;
    logic              ge;

    // remainder stays below divisor, so one extra bit holds the trial
    assign trial = {rem_reg, q_reg[PROD_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(PROD_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            q_reg   <= {q_reg[PROD_W-2:0], ge};
            rem_reg <= ge ? IDX_W'(trial - {1'b0, den_reg}) : trial[IDX_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### rtl/binomial_coefficient_top.sv
// Trivial cases (a result of zero or one) skip the recurrence; otherwise
// the block runs min(k, n-k) recurrence steps.
// Requests are taken one at a time; each recurrence step is a multiply, a divider launch,
// the shifts of the bit-serial divider and a collect.
// The result register lets a new request start while a result waits.
// Reset: rst_n asynchronous active low clears the sequencer and valid flag.
// ---------------------------------------------------------------------------
// binomial_coefficient_top
// Computes C(n,k) by acc = acc*(n-i+1)/i with a shared serial divider.
// ---------------------------------------------------------------------------
`default_nettype none

module binomial_coefficient_top #(
    parameter int MAX_N = binc_pkg::MAX_N_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [6:0] n_value, [13:7] k_value, [15:14] zero
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // [59:0] coefficient, [63:60] zero
);

    import binc_pkg::*;

    binc_state_t       state_reg, state_next;

    logic [N_W-1:0]    n_reg, n_next;       // range-checked n
    logic [IDX_W-1:0]  kk_reg, kk_next;     // min(k, n-k)
    logic [IDX_W-1:0]  i_reg, i_next;       // step index
    logic [ACC_W-1:0]  acc_reg, acc_next;   // running C(n, i)
    logic [PROD_W-1:0] prod_reg;
    logic              prod_load;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [ACC_W-1:0]  m_data_reg;
    logic              m_load;

    logic [FIELD_W-1:0] n_in, k_in;
    logic [FIELD_W-1:0] nmk;                // n - k, valid when k <= n
    logic [N_W-1:0]     num;                // n - i + 1
    logic               s_accept;

    logic               div_start;
    logic               div_done;
    logic [PROD_W-1:0]  div_q;

    // first cycle in ST_DIV flag: launches the divider once per step
    logic               first_div_reg;
    logic               step_idx_ok;

    assign n_in     = s_tdata[FIELD_W-1:0];
    assign k_in     = s_tdata[2*FIELD_W-1:FIELD_W];
    assign nmk      = n_in - k_in;
    assign num      = n_reg - {1'b0, i_reg} + N_W'(1);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // -----------------------------------------------------------------------
    // shared divider: exact division of acc*(n-i+1) by i
    // -----------------------------------------------------------------------
    binc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (i_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        kk_reg  <= kk_next;
        i_reg   <= i_next;
        acc_reg <= acc_next;
        if (prod_load)
            prod_reg <= {{N_W{1'b0}}, acc_reg} * {{ACC_W{1'b0}}, num};
        if (m_load)
            m_data_reg <= acc_reg;
    end

    // -----------------------------------------------------------------------
    // sequencer
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        kk_next       = kk_reg;
        i_next        = i_reg;
        acc_next      = acc_reg;
        prod_load     = 1'b0;
        div_start     = 1'b0;
        m_load        = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    n_next = n_in[N_W-1:0];
                    i_next = IDX_W'(1);
                    if (n_in[FIELD_W-1] || k_in[FIELD_W-1] ||
                        (n_in > FIELD_W'(MAX_N)) || (k_in > n_in))
                    begin
                        // out of range or k above n
                        acc_next   = '0;
                        state_next = ST_FIN;
                    end
                    else if ((k_in == '0) || (k_in == n_in))
                    begin
                        acc_next   = ACC_W'(1);
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        acc_next   = ACC_W'(1);
                        kk_next    = (nmk < k_in) ? nmk[IDX_W-1:0] : k_in[IDX_W-1:0];
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                prod_load  = 1'b1;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                // divider starts on the cycle after the product lands
                div_start = first_div_reg;
                if (div_done)
                begin
                    acc_next = div_q[ACC_W-1:0];
                    if (i_reg == kk_reg)
                        state_next = ST_FIN;
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_MUL;
                    end
                end
            end

            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_load        = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_div_reg <= 1'b0;
        else
            first_div_reg <= (state_reg == ST_MUL);
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(64-ACC_W){1'b0}}, m_data_reg};

    // -----------------------------------------------------------------------
    // checks
    // -----------------------------------------------------------------------
    assign step_idx_ok = (i_reg != '0) && (i_reg <= kk_reg);

    `include "binomial_coefficient_top_assert.svh"

    `BINC_ASSERT(a_done_in_div, div_done |-> (state_reg == ST_DIV), "divider done outside DIV")
    `BINC_ASSERT(a_idx_range, (state_reg == ST_MUL) |-> step_idx_ok, "step index out of range")
    `BINC_ASSERT(a_mul_to_div, (state_reg == ST_MUL) |=> first_div_reg, "divider not launched")
    `BINC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_reg == ST_IDLE), "not idle after reset")
    `BINC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_tvalid_reg, "result valid after reset")

endmodule

`default_nettype wire

### verif/binomial_coefficient_checker.sv
// ---------------------------------------------------------------------------
// binomial_coefficient_checker
// Watches both channels of the binomial coefficient block, predicts C(n,k)
// for each accepted request and compares it with the next result.
// ---------------------------------------------------------------------------
`default_nettype none

module binomial_coefficient_checker #(
    parameter int MAX_N = binc_pkg::MAX_N_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [6:0] n_value, [13:7] k_value, [15:14] zero
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,   // [59:0] coefficient, [63:60] zero
    output int               fail_count,
    output int               outstanding
);

    import binc_pkg::*;

    logic [ACC_W-1:0] coeff_queue[$];

    // Wide accumulator, so every step's product stays exact.
    function automatic logic [ACC_W-1:0] coefficient_of(input logic signed [FIELD_W-1:0] n,
                                                        input logic signed [FIELD_W-1:0] k);
        logic [127:0] acc;
        int           nv;
        int           kv;
        nv = n;
        kv = k;
        if (nv < 0 || kv < 0 || kv > nv || nv > MAX_N)
            return '0;
        if (kv > nv - kv)
            kv = nv - kv;
        acc = 128'd1;
        for (int i = 1; i <= kv; i++)
            acc = acc * 128'(nv - i + 1) / 128'(i);
        return acc[ACC_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : watch
        logic [ACC_W-1:0] expected;
        if (rst_n)
        begin
            // results first, so a stray result is never matched to a request
            // accepted on the same edge
            if (m_tvalid && m_tready)
            begin
                if (coeff_queue.size() == 0)
                    report_mismatch($sformatf("result %0d with no request waiting",
                                              m_tdata[ACC_W-1:0]));
                else
                begin
                    expected = coeff_queue.pop_front();
                    if (m_tdata[ACC_W-1:0] !== expected)
                        report_mismatch($sformatf("coefficient %0d, expected %0d",
                                                  m_tdata[ACC_W-1:0], expected));
                end
            end
            if (s_tvalid && s_tready)
                coeff_queue = {coeff_queue, coefficient_of(s_tdata[FIELD_W-1:0],
                                                           s_tdata[2*FIELD_W-1:FIELD_W])};
            outstanding = coeff_queue.size();
        end
    end

endmodule

`default_nettype wire

### verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Regression for binomial_coefficient_top: directed corners, then random
// requests under three idle profiles; a separate checker predicts and compares.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    import binc_pkg::*;

    // used for the drain at the end
    localparam int DRAIN_CYCLES = 2400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [6:0] n_value, [13:7] k_value, [15:14] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // [59:0] coefficient, [63:60] zero

    int fail_count;
    int outstanding;

    // idle odds in percent per cycle, changed by the stimulus between phases
    int send_gap_pct;
    int recv_stall_pct;

    binomial_coefficient_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    binomial_coefficient_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 12-unit clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side: tready is redrawn each falling edge; a stall percentage of
    // zero keeps it high for the whole phase.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One request: optional idle cycles, then hold tvalid until the edge at
    // which tready is seen high. Returns at the falling edge after the
    // handshake, so the next call (or the caller) owns tvalid from there.
    task automatic send_request(input logic signed [FIELD_W-1:0] n,
                                input logic signed [FIELD_W-1:0] k);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, k, n};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender stops until every result already owed has come back.
    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed pairs (0 <= k <= n), most with small n since each
    // step of the block runs a bit-serial divide; the rest are raw 7-bit noise
    // that covers negative fields, k above n and every bit of both fields.
    task automatic send_random(input int count);
        int                         nv;
        logic signed [FIELD_W-1:0]  n;
        logic signed [FIELD_W-1:0]  k;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 75)
            begin
                if ($urandom_range(9) == 0)
                    nv = $urandom_range(63, 25);
                else
                    nv = $urandom_range(24, 0);
                n = FIELD_W'(nv);
                case ($urandom_range(9))
                    0:       k = '0;
                    1:       k = n;
                    default: k = FIELD_W'($urandom_range(nv, 0));
                endcase
            end
            else
            begin
                n = FIELD_W'($urandom);
                k = FIELD_W'($urandom);
            end
            send_request(n, k);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_gap_pct   = 35;
        recv_stall_pct = 72;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners: trivial ones, zero cases, field extremes, largest
        send_request(7'sd0, 7'sd0);          // C(0,0) = 1
        send_request(7'sd1, 7'sd0);
        send_request(7'sd1, 7'sd1);
        send_request(7'sd63, 7'sd0);         // k zero at top n
        send_request(7'sd63, 7'sd63);        // k equal to n
        send_request(7'sd63, 7'sd1);
        send_request(7'sd63, 7'sd62);        // mirrored to k = 1
        send_request(-7'sd64, 7'sd0);        // negative n
        send_request(7'sd0, -7'sd64);        // negative k
        send_request(-7'sd1, -7'sd1);
        send_request(-7'sd64, -7'sd64);
        send_request(7'sd63, -7'sd64);
        send_request(-7'sd1, 7'sd5);
        send_request(7'sd5, 7'sd6);          // k just above n
        send_request(7'sd0, 7'sd63);         // k far above n
        send_request(7'sd7, 7'sd3);
        send_request(7'sd20, 7'sd10);
        send_request(7'sd62, 7'sd31);
        send_request(7'sd63, 7'sd30);
        send_request(7'sd63, 7'sd31);        // largest coefficient
        send_request(7'sd63, 7'sd32);        // same value by symmetry
        send_request(7'sd2, 7'sd1);

        send_random(75);

        // swap the idle profiles; start the phase from an empty pipe
        wait_for_results();
        send_gap_pct   = 72;
        recv_stall_pct = 35;
        send_random(90);

        // no idling at all: back-to-back requests, result side always ready
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        send_random(90);

        // drain, then linger in case a stray result shows up
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("binomial_coefficient_top regression: pass");
        else
            $display("binomial_coefficient_top regression: fail");
        $finish;
    end

    // Watchdog: well beyond ~280 requests at their slowest plus all stalls.
    initial
    begin
        #40_000_000;
        $display("binomial_coefficient_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
